>>> hdl/sskv_pkg.sv
// shared widths, command codes and types for the sparse-set key-value table
package sskv_pkg;

    // key and value widths
    localparam int KEY_BITS   = 10;
    localparam int VALUE_BITS = 32;
    localparam int CMD_BITS   = 3;
    localparam int DEPTH      = 2 ** KEY_BITS;

    // table capacity as an occupancy-width value
    localparam logic [KEY_BITS:0] CAPACITY = (KEY_BITS + 1)'(1) << KEY_BITS;

    // command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    // one dense slot: key and value side by side
    typedef struct packed {
        logic        [KEY_BITS-1:0]   key;
        logic signed [VALUE_BITS-1:0] value;
    } t_pair;

endpackage

>>> hdl/sskv_dense_ram.sv
// dense key/value store: one write port, two registered read ports
module sskv_dense_ram
    import sskv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [KEY_BITS-1:0] i_waddr,
    input  t_pair               i_wdata,
    input  logic [KEY_BITS-1:0] i_raddr_a,
    input  logic [KEY_BITS-1:0] i_raddr_b,
    output t_pair               o_rdata_a,
    output t_pair               o_rdata_b
);

    t_pair r_mem [DEPTH];
    t_pair r_rdata_a;
    t_pair r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/sparse_set_key_value_table.sv
// top level of the sparse-set key-value table
//
// Request channel: a command (add/update, search, remove, clear, read slot)
// with key, value and slot is taken at a rising edge where start is high
// and busy is low. busy stays high while the command is in progress.
// Result channel: o_valid is high for exactly one cycle and carries found,
// key, value and the occupancy after the command; the receiver cannot
// stall, so the result is simply presented for that one cycle.
// The request is taken together with its position-map read; the dense
// store is read in S_MAP, and the write-back and result are formed in
// S_DENSE and registered onto the ports. A new request is taken only once
// the result is on the ports, paced by the dependent reads: the position
// map, then the dense store (both synchronous memories), then the write-back.
// Remove reads the hit slot and the last live slot through the two read
// ports of the dense store at once, then writes the moved pair and
// its new position in the same write-back cycle.
// Reset clears the occupancy and the sequencer, then a clearing pass writes
// zero into all 1024 position-map entries, one per cycle, so busy stays high
// until the pass has written the last entry. The dense store keeps its
// contents, since every read of it is checked against the occupancy.
module sparse_set_key_value_table
    import sskv_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [CMD_BITS-1:0]          i_cmd,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic signed [VALUE_BITS-1:0] i_value_in,
    input  logic [KEY_BITS-1:0]          i_slot,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [KEY_BITS-1:0]          o_key_out,
    output logic signed [VALUE_BITS-1:0] o_value_out,
    output logic [KEY_BITS:0]            o_occupancy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAP   = 4'b0010,
        S_DENSE = 4'b0100,
        S_INIT  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    t_cmd                          r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic signed [VALUE_BITS-1:0]  r_value;
    logic [KEY_BITS-1:0]           r_slot;
    logic [KEY_BITS-1:0]           r_pos;
    logic [KEY_BITS:0]             r_count, n_count;
    logic [KEY_BITS-1:0]           r_init_addr;
    logic [KEY_BITS-1:0]           r_pos_map [DEPTH];

    logic                          r_valid;
    logic                          r_found, n_found;
    logic [KEY_BITS-1:0]           r_key_out, n_key_out;
    logic signed [VALUE_BITS-1:0]  r_value_out, n_value_out;

    logic                          accept;
    logic                          pm_we;
    logic [KEY_BITS-1:0]           pm_waddr;
    logic [KEY_BITS-1:0]           pm_wdata;
    logic                          dn_we;
    logic [KEY_BITS-1:0]           dn_waddr;
    t_pair                         dn_wdata;
    logic [KEY_BITS-1:0]           dn_raddr_a;
    logic [KEY_BITS-1:0]           dn_raddr_b;
    t_pair                         dn_rdata_a;
    t_pair                         dn_rdata_b;
    logic                          hit;
    logic                          slot_live;
    logic [KEY_BITS:0]             last;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_key   <= i_key;
            r_value <= i_value_in;
            r_slot  <= i_slot;
        end
    end

    // position map: read at request time, written back in the last cycle
    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pos_map[pm_waddr] <= pm_wdata;
        end
        if (accept) begin
            r_pos <= r_pos_map[i_key];
        end
    end

    // dense store read addresses: looked-up slot (or requested slot), last live slot
    assign last       = r_count - (KEY_BITS + 1)'(1);
    assign dn_raddr_a = (r_cmd == CMD_READ) ? r_slot : r_pos;
    assign dn_raddr_b = last[KEY_BITS-1:0];

    sskv_dense_ram u_dense (
        .i_clk     (i_clk),
        .i_we      (dn_we),
        .i_waddr   (dn_waddr),
        .i_wdata   (dn_wdata),
        .i_raddr_a (dn_raddr_a),
        .i_raddr_b (dn_raddr_b),
        .o_rdata_a (dn_rdata_a),
        .o_rdata_b (dn_rdata_b)
    );

    // membership checks against the live count
    assign hit       = ({1'b0, r_pos} < r_count) && (dn_rdata_a.key == r_key);
    assign slot_live = ({1'b0, r_slot} < r_count);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:   n_state = S_DENSE;
            S_DENSE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // write-back and result in the last cycle, position map clearing after reset
    always_comb begin
        n_count     = r_count;
        n_found     = 1'b0;
        n_key_out   = '0;
        n_value_out = '0;
        pm_we       = 1'b0;
        pm_waddr    = r_key;
        pm_wdata    = r_count[KEY_BITS-1:0];
        dn_we       = 1'b0;
        dn_waddr    = r_pos;
        dn_wdata    = '{key: r_key, value: r_value};
        if (r_state == S_INIT) begin
            pm_we    = 1'b1;
            pm_waddr = r_init_addr;
            pm_wdata = '0;
        end else if (r_state == S_DENSE) begin
            case (r_cmd)
                CMD_ADD: begin
                    n_key_out = r_key;
                    n_found   = hit;
                    if (hit) begin
                        dn_we = 1'b1;
                    end else if (r_count < CAPACITY) begin
                        dn_we    = 1'b1;
                        dn_waddr = r_count[KEY_BITS-1:0];
                        pm_we    = 1'b1;
                        n_count  = r_count + (KEY_BITS + 1)'(1);
                    end
                end
                CMD_SEARCH: begin
                    n_key_out = r_key;
                    n_found   = hit;
                    if (hit) begin
                        n_value_out = dn_rdata_a.value;
                    end
                end
                CMD_REMOVE: begin
                    n_key_out = r_key;
                    n_found   = hit;
                    if (hit) begin
                        // move the last live pair into the freed slot
                        dn_we    = 1'b1;
                        dn_wdata = dn_rdata_b;
                        pm_we    = 1'b1;
                        pm_waddr = dn_rdata_b.key;
                        pm_wdata = r_pos;
                        n_count  = last;
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                CMD_READ: begin
                    if (slot_live) begin
                        n_found     = 1'b1;
                        n_key_out   = dn_rdata_a.key;
                        n_value_out = dn_rdata_a.value;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_init_addr <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= (r_state == S_DENSE);
            if (r_state == S_INIT) begin
                r_init_addr <= r_init_addr + KEY_BITS'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DENSE) begin
            r_found     <= n_found;
            r_key_out   <= n_key_out;
            r_value_out <= n_value_out;
        end
    end

    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_key_out   = r_key_out;
    assign o_value_out = r_value_out;
    assign o_occupancy = r_count;

    // the result strobe only appears once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // occupancy never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAPACITY)
        else $error("occupancy above capacity");

    // occupancy only moves together with a result
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(i_rst_n)) |-> $stable(r_count))
        else $error("occupancy changed without a result");

    // a taken request always comes back with a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("result missing after request");

endmodule
